[src/text_terminal_writer_top_defines.svh]
// ----------------------------------------------------------------------------
// text terminal writer assertion macros
// concurrent checks on the rising clock edge, with or without reset gating
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_WRITER_TOP_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define TTW_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("text terminal writer check failed");
// checked at every edge, reset included
`define TTW_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) prop) \
	else $error("text terminal writer check failed");
`else
`define TTW_ASSERT(name, prop)
`define TTW_ASSERT_ALWAYS(name, prop)
`endif

`endif

[src/ttw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_pkg
// shared types and constants of the text terminal writer
// ----------------------------------------------------------------------------
package ttw_pkg;

	// payload field widths
	localparam int ACTION_W   = 2;
	localparam int CHAR_W     = 8;
	localparam int READ_ROW_W = 5;
	localparam int READ_COL_W = 7;
	localparam int CUR_ROW_W  = 5;
	localparam int CUR_COL_W  = 7;
	localparam int CUR_POS_W  = 11;
	localparam int COLOR_W    = 8;
	localparam int CELL_W     = CHAR_W + COLOR_W;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	// special characters
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

	// attribute after reset
	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd10;

	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_DONE  = 5'b10000
	} ttw_state_t;

endpackage

[src/ttw_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw channel interfaces
// command, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface ttw_cmd_if import ttw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [CHAR_W-1:0]     char_code;
	logic [READ_ROW_W-1:0] read_row;
	logic [READ_COL_W-1:0] read_col;

	modport source (output valid, action, char_code, read_row, read_col, input ready);
	modport sink (input valid, action, char_code, read_row, read_col, output ready);
endinterface

interface ttw_rsp_if import ttw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CUR_ROW_W-1:0] cursor_row;
	logic [CUR_COL_W-1:0] cursor_col;
	logic [CUR_POS_W-1:0] cursor_position;
	logic [CHAR_W-1:0]    cell_char;
	logic [COLOR_W-1:0]   cell_color;
	logic                 scrolled;

	modport source (output valid, cursor_row, cursor_col, cursor_position, cell_char,
		cell_color, scrolled, input ready);
	modport sink (input valid, cursor_row, cursor_col, cursor_position, cell_char,
		cell_color, scrolled, output ready);
endinterface

interface ttw_cfg_if import ttw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] text_color;

	modport source (output valid, text_color, input ready);
	modport sink (input valid, text_color, output ready);
endinterface

[src/ttw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ttw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/text_terminal_writer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_writer_top
// text screen of ROWS x COLUMNS character cells with a cursor: put, read, clear
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | beat when
//  cmd     | in  | action, char_code, read_row, read_col          | valid & ready
//  rsp     | out | cursor_row/col/position, cell_char/color, scr  | valid & ready
//  cfg     | in  | text_color                                     | valid & ready
//
// put without scroll, unused action and out-of-range read: the command beat
// moves to the done state, where the result register loads once rsp is free and
// the command channel reopens; an in-range read first waits in the read state
// clear and scroll walk the whole cell ram one address per cycle through a two
// stage read/write pipe; after reset a blanking pass over every cell runs before
// the first command beat; cfg is always ready
// one item in flight; the next command is taken while a result waits in rsp
`include "text_terminal_writer_top_defines.svh"

module text_terminal_writer_top import ttw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic    clk,
	input  logic    arst_n,
	ttw_cmd_if.sink   cmd,
	ttw_rsp_if.source rsp,
	ttw_cfg_if.sink   cfg
);

	localparam int NCELLS = ROWS * COLUMNS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ADDR_W = $clog2(NCELLS);

	localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NCELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_END = ADDR_W'(NCELLS - COLUMNS);

	// control and cursor
	ttw_state_t         st_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [COLOR_W-1:0] text_color_q;

	// sweep engine (reset blanking, clear, scroll)
	logic [COLOR_W-1:0] sweep_color_q;
	logic               scroll_q;
	logic [ADDR_W-1:0]  idx_q;
	logic               valid_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               copy_s1;

	// result of the item in flight
	logic [CHAR_W-1:0]  res_char_q;
	logic [COLOR_W-1:0] res_color_q;
	logic               res_scr_q;

	// output register
	logic                 out_valid_q;
	logic [CUR_ROW_W-1:0] out_row_q;
	logic [CUR_COL_W-1:0] out_col_q;
	logic [CUR_POS_W-1:0] out_pos_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic [COLOR_W-1:0]   out_color_q;
	logic                 out_scr_q;

	// ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// decode
	logic              cmd_beat;
	logic              is_put;
	logic              is_nl;
	logic              is_bs;
	logic              at_corner;
	logic              read_ok;
	logic [ADDR_W-1:0] cur_idx;
	logic [ADDR_W-1:0] read_idx;
	logic              sweeping;
	logic              sweep_issue;
	logic              sweep_copy;
	logic              sweep_last;
	logic              out_load;
	logic [CELL_W-1:0] blank_cell;

	assign cmd.ready = (st_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_beat  = cmd.valid && cmd.ready;

	assign is_put    = (cmd.action == ACT_PUT);
	assign is_nl     = (cmd.char_code == CH_NEWLINE);
	assign is_bs     = (cmd.char_code == CH_BACKSPACE);
	assign at_corner = (row_q == '0) && (col_q == '0);
	assign read_ok   = (int'(cmd.read_row) < ROWS) && (int'(cmd.read_col) < COLUMNS);

	// linear cell index of the cursor and of the requested read
	assign cur_idx  = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);
	assign read_idx = ADDR_W'(cmd.read_row) * COLS_A + ADDR_W'(cmd.read_col);

	// sweep: issue one address a cycle, write it back in the cycle after
	assign sweeping    = (st_q == ST_INIT) || (st_q == ST_SWEEP);
	assign sweep_last  = valid_s1 && (addr_s1 == LAST_IDX);
	assign sweep_issue = sweeping && !sweep_last;
	assign sweep_copy  = scroll_q && (idx_q < COPY_END);
	assign blank_cell  = {sweep_color_q, CH_BLANK};

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q + COLS_A;
		if (sweep_issue && sweep_copy) begin
			ram_re = 1'b1;
		end else if (cmd_beat && (cmd.action == ACT_READ) && read_ok) begin
			ram_re    = 1'b1;
			ram_raddr = read_idx;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = copy_s1 ? ram_rdata : blank_cell;
		if (valid_s1) begin
			ram_we = 1'b1;
		end else if (cmd_beat && is_put && !is_nl) begin
			ram_we = 1'b1;
			if (is_bs) begin
				// blank the cell the cursor steps back onto
				ram_waddr = at_corner ? cur_idx : cur_idx - ADDR_W'(1);
				ram_wdata = {text_color_q, CH_BLANK};
			end else begin
				ram_waddr = cur_idx;
				ram_wdata = {text_color_q, cmd.char_code};
			end
		end
	end

	ttw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (NCELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_load = (st_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg.valid && cfg.ready) begin
			text_color_q <= cfg.text_color;
		end
	end

	// sweep pipe stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			addr_s1  <= '0;
			copy_s1  <= 1'b0;
		end else begin
			valid_s1 <= sweep_issue;
			addr_s1  <= idx_q;
			copy_s1  <= sweep_copy;
		end
	end

	// main control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_INIT;
			row_q         <= '0;
			col_q         <= '0;
			idx_q         <= '0;
			scroll_q      <= 1'b0;
			sweep_color_q <= RESET_COLOR;
			res_char_q    <= '0;
			res_color_q   <= '0;
			res_scr_q     <= 1'b0;
		end else begin
			if (sweep_issue) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			case (st_q)
				ST_INIT: begin
					if (sweep_last) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_beat) begin
						res_char_q    <= '0;
						res_color_q   <= '0;
						res_scr_q     <= 1'b0;
						idx_q         <= '0;
						sweep_color_q <= text_color_q;
						scroll_q      <= 1'b0;
						st_q          <= ST_DONE;
						case (cmd.action)
							ACT_PUT: begin
								if (is_bs) begin
									if (col_q != '0) begin
										col_q <= col_q - COL_W'(1);
									end else if (row_q != '0) begin
										row_q <= row_q - ROW_W'(1);
										col_q <= LAST_COL;
									end
								end else if (is_nl || (col_q == LAST_COL)) begin
									// next row, scroll when below the bottom
									col_q <= '0;
									if (row_q == LAST_ROW) begin
										res_scr_q <= 1'b1;
										scroll_q  <= 1'b1;
										st_q      <= ST_SWEEP;
									end else begin
										row_q <= row_q + ROW_W'(1);
									end
								end else begin
									col_q <= col_q + COL_W'(1);
								end
							end
							ACT_READ: begin
								if (read_ok) begin
									st_q <= ST_READ;
								end
							end
							ACT_CLEAR: begin
								row_q <= '0;
								col_q <= '0;
								st_q  <= ST_SWEEP;
							end
							default: begin
								st_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					res_char_q  <= ram_rdata[CHAR_W-1:0];
					res_color_q <= ram_rdata[CELL_W-1:CHAR_W];
					st_q        <= ST_DONE;
				end
				ST_SWEEP: begin
					if (sweep_last) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q   <= CUR_ROW_W'(row_q);
			out_col_q   <= CUR_COL_W'(col_q);
			out_pos_q   <= CUR_POS_W'(cur_idx);
			out_char_q  <= res_char_q;
			out_color_q <= res_color_q;
			out_scr_q   <= res_scr_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.cursor_row      = out_row_q;
	assign rsp.cursor_col      = out_col_q;
	assign rsp.cursor_position = out_pos_q;
	assign rsp.cell_char       = out_char_q;
	assign rsp.cell_color      = out_color_q;
	assign rsp.scrolled        = out_scr_q;

	// cursor never leaves the screen
	`TTW_ASSERT(a_cursor_range, (int'(row_q) < ROWS) && (int'(col_q) < COLUMNS))
	// one item in flight: a command beat closes the command channel next cycle
	`TTW_ASSERT(a_one_in_flight, cmd_beat |=> !cmd.ready)
	// the sweep stops issuing once the last cell is written
	`TTW_ASSERT(a_sweep_ends, sweep_last |=> !valid_s1)
	// no ram write while waiting on read data or on the result register
	`TTW_ASSERT_ALWAYS(a_no_stray_write, ((st_q == ST_READ) || (st_q == ST_DONE)) |-> !ram_we)

endmodule
